### design/rdhd_pkg.sv
// Shared types and constants for the readout datagram hit decoder.
`timescale 1ns / 1ps

package rdhd_pkg;

   // Default depth of the queue between the front and back parts.
   localparam int QUEUE_DEPTH = 4;

   localparam logic [31:0] TRAILER_WORD = 32'hffff_ffff;

   // Position of the next word within a datagram.
   typedef enum logic [3:0] {
      POS_LINK   = 4'b0001,
      POS_COUNT  = 4'b0010,
      POS_HEADER = 4'b0100,
      POS_HITS   = 4'b1000
   } pos_type;

   typedef struct packed {
      logic [31:0] raw_word;
      logic        end_of_datagram;
   } req_type;

   typedef struct packed {
      logic [5:0]  channel;
      logic [9:0]  charge;
      logic [7:0]  arrival_time;
      logic [2:0]  rel_bunch;
      logic        neighbor;
      logic [1:0]  hit_flags;
      logic [7:0]  chip_id;
      logic [11:0] bunch_id;
      logic [3:0]  header_flags;
      logic [31:0] trigger_count;
      logic [12:0] link_info;
      logic        short_error;
   } rsp_type;

   // Work handed from the front to the back: a swapped hit word or a short error,
   // with the header context captured when the word was taken.
   typedef struct packed {
      logic        short_error;
      logic [31:0] hit_word;
      logic [23:0] chip_header;
      logic [31:0] trigger_count;
      logic [12:0] link_info;
   } cmd_type;

endpackage

### design/rdhd_front.sv
// Front part: byte swap, word position tracking, header capture, hit/trailer classification.
`timescale 1ns / 1ps

module rdhd_front (
   input  logic              clock,
   input  logic              reset,
   input  logic              accept,
   input  rdhd_pkg::req_type req_data,
   output logic              cmd_push,
   output rdhd_pkg::cmd_type cmd_data
);

   rdhd_pkg::pos_type pos_ff, pos_in;
   logic              trailer_ff, trailer_in;
   logic [12:0]       link_ff, link_in;
   logic [31:0]       count_ff, count_in;
   logic [23:0]       header_ff, header_in;
   logic [31:0]       word;
   logic              last;
   logic              is_hit;

   assign word = {req_data.raw_word[7:0], req_data.raw_word[15:8],
                  req_data.raw_word[23:16], req_data.raw_word[31:24]};
   assign last = req_data.end_of_datagram;

   always_comb begin
      pos_in     = pos_ff;
      trailer_in = trailer_ff;
      link_in    = link_ff;
      count_in   = count_ff;
      header_in  = header_ff;
      is_hit     = 1'b0;
      unique case (pos_ff)
         rdhd_pkg::POS_LINK: begin
            link_in = {word[15:10], word[8], word[5:0]};
            pos_in  = rdhd_pkg::POS_COUNT;
         end
         rdhd_pkg::POS_COUNT: begin
            count_in = word;
            pos_in   = rdhd_pkg::POS_HEADER;
         end
         rdhd_pkg::POS_HEADER: begin
            header_in = {word[31:24], word[15:0]};
            pos_in    = rdhd_pkg::POS_HITS;
         end
         rdhd_pkg::POS_HITS: begin
            if (!trailer_ff) begin
               if (word == rdhd_pkg::TRAILER_WORD) begin
                  trailer_in = 1'b1;
               end else begin
                  is_hit = 1'b1;
               end
            end
         end
         default: begin
            pos_in = rdhd_pkg::POS_LINK;
         end
      endcase
      if (last) begin
         pos_in     = rdhd_pkg::POS_LINK;
         trailer_in = 1'b0;
      end
   end

   // Short datagram: ended on word 0, 1 or 2.
   always_comb begin
      cmd_data.short_error   = last && (pos_ff != rdhd_pkg::POS_HITS);
      cmd_data.hit_word      = word;
      cmd_data.chip_header   = header_ff;
      cmd_data.trigger_count = count_ff;
      cmd_data.link_info     = link_ff;
      cmd_push               = accept && (is_hit || cmd_data.short_error);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pos_ff     <= rdhd_pkg::POS_LINK;
         trailer_ff <= 1'b0;
         link_ff    <= '0;
         count_ff   <= '0;
         header_ff  <= '0;
      end else if (accept) begin
         pos_ff     <= pos_in;
         trailer_ff <= trailer_in;
         link_ff    <= link_in;
         count_ff   <= count_in;
         header_ff  <= header_in;
      end
   end

endmodule

### design/rdhd_queue.sv
// Short queue of decoded work between the front and back parts.
`timescale 1ns / 1ps

module rdhd_queue #(
   parameter int DEPTH = rdhd_pkg::QUEUE_DEPTH
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              push,
   input  rdhd_pkg::cmd_type push_data,
   output logic              full,
   input  logic              pop,
   output rdhd_pkg::cmd_type pop_data,
   output logic              empty
);

   localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CNT_W = $clog2(DEPTH + 1);

   rdhd_pkg::cmd_type  slot_ff [DEPTH];
   logic [PTR_W-1:0]   wr_ptr_ff, rd_ptr_ff;
   logic [CNT_W-1:0]   count_ff;
   logic               do_push, do_pop;

   assign full     = (count_ff == CNT_W'(DEPTH));
   assign empty    = (count_ff == '0);
   assign do_push  = push && !full;
   assign do_pop   = pop && !empty;
   assign pop_data = slot_ff[rd_ptr_ff];

   function automatic logic [PTR_W-1:0] next_ptr(input logic [PTR_W-1:0] ptr);
      next_ptr = (ptr == PTR_W'(DEPTH - 1)) ? '0 : ptr + 1'b1;
   endfunction

   always_ff @(posedge clock) begin
      if (do_push) begin
         slot_ff[wr_ptr_ff] <= push_data;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         if (do_push) begin
            wr_ptr_ff <= next_ptr(wr_ptr_ff);
         end
         if (do_pop) begin
            rd_ptr_ff <= next_ptr(rd_ptr_ff);
         end
         if (do_push && !do_pop) begin
            count_ff <= count_ff + 1'b1;
         end else if (do_pop && !do_push) begin
            count_ff <= count_ff - 1'b1;
         end
      end
   end

endmodule

### design/rdhd_back.sv
// Back part: splits hit words into result fields and holds the result register.
`timescale 1ns / 1ps

module rdhd_back (
   input  logic              clock,
   input  logic              reset,
   input  logic              cmd_empty,
   input  rdhd_pkg::cmd_type cmd_data,
   output logic              cmd_pop,
   output logic              rsp_empty,
   input  logic              rsp_pop,
   output rdhd_pkg::rsp_type rsp_data
);

   logic              valid_ff;
   rdhd_pkg::rsp_type rsp_ff, rsp_in;
   logic [31:0]       w;
   logic [23:0]       hdr;

   assign w   = cmd_data.hit_word;
   assign hdr = cmd_data.chip_header;

   always_comb begin
      if (cmd_data.short_error) begin
         rsp_in             = '0;
         rsp_in.short_error = 1'b1;
      end else begin
         rsp_in.channel       = w[27:22];
         rsp_in.charge        = w[21:12];
         rsp_in.arrival_time  = w[11:4];
         rsp_in.rel_bunch     = w[2:0];
         rsp_in.neighbor      = w[3];
         rsp_in.hit_flags     = {w[30], w[28]};
         rsp_in.chip_id       = hdr[23:16];
         rsp_in.bunch_id      = hdr[11:0];
         rsp_in.header_flags  = hdr[15:12];
         rsp_in.trigger_count = cmd_data.trigger_count;
         rsp_in.link_info     = cmd_data.link_info;
         rsp_in.short_error   = 1'b0;
      end
   end

   // Refill the output register when it is free or being drained this cycle.
   assign cmd_pop   = !cmd_empty && (!valid_ff || rsp_pop);
   assign rsp_empty = !valid_ff;
   assign rsp_data  = rsp_ff;

   always_ff @(posedge clock) begin
      if (cmd_pop) begin
         rsp_ff <= rsp_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (cmd_pop) begin
         valid_ff <= 1'b1;
      end else if (rsp_pop) begin
         valid_ff <= 1'b0;
      end
   end

endmodule

### design/readout_datagram_hit_decoder.sv
// Top level of the readout datagram hit decoder.
`timescale 1ns / 1ps
//
//   channel   ports                      word
//   -------   ------------------------   ----------------------------------------
//   request   req_push/req_full/req_data one raw datagram word + end marker
//   response  rsp_pop/rsp_empty/rsp_data one decoded hit or short-datagram error
//
// One request word per cycle while req_full is low. A result reaches the rsp_
// ports through a queue write, then an output register load.
// The queue (QUEUE_DEPTH entries) decouples the front from the output
// register; req_full rises only when the queue is full, and then stalls
// every word, even ones that yield no result (header, trailer, tail words).
// Synchronous reset clears position, trailer flag, headers, queue and valid.

module readout_datagram_hit_decoder #(
   parameter int QUEUE_DEPTH = rdhd_pkg::QUEUE_DEPTH
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_push,
   output logic              req_full,
   input  rdhd_pkg::req_type req_data,
   output logic              rsp_empty,
   input  logic              rsp_pop,
   output rdhd_pkg::rsp_type rsp_data
);

   logic              accept;
   logic              cmd_push;
   rdhd_pkg::cmd_type cmd_in;
   logic              cmd_pop;
   logic              cmd_empty;
   rdhd_pkg::cmd_type cmd_out;

   // Words are taken whenever the queue has room.
   assign accept = req_push && !req_full;

   rdhd_front u_front (
      .clock    (clock),
      .reset    (reset),
      .accept   (accept),
      .req_data (req_data),
      .cmd_push (cmd_push),
      .cmd_data (cmd_in)
   );

   rdhd_queue #(
      .DEPTH (QUEUE_DEPTH)
   ) u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (cmd_push),
      .push_data (cmd_in),
      .full      (req_full),
      .pop       (cmd_pop),
      .pop_data  (cmd_out),
      .empty     (cmd_empty)
   );

   rdhd_back u_back (
      .clock     (clock),
      .reset     (reset),
      .cmd_empty (cmd_empty),
      .cmd_data  (cmd_out),
      .cmd_pop   (cmd_pop),
      .rsp_empty (rsp_empty),
      .rsp_pop   (rsp_pop),
      .rsp_data  (rsp_data)
   );

endmodule

### dv/readout_datagram_hit_decoder_test.sv
// Self-checking testbench for the readout datagram hit decoder.
`timescale 1ns / 1ps

module readout_datagram_hit_decoder_test;

   // Receiver hold-off used to fill the queue and stall the input side.
   localparam int HOLD_CYCLES  = 80;
   localparam int RANDOM_WORDS = 300;

   logic              clock     = 1'b0;
   logic              reset     = 1'b1;
   logic              req_push  = 1'b0;
   logic              req_full;
   rdhd_pkg::req_type req_data  = '0;
   logic              rsp_empty;
   logic              rsp_pop   = 1'b0;
   rdhd_pkg::rsp_type rsp_data;

   // Predictor state: mirrors the decoder's datagram position, trailer flag
   // and the three captured header words.
   rdhd_pkg::pos_type next_pos     = rdhd_pkg::POS_LINK;
   logic              past_trailer = 1'b0;
   logic [12:0]       link_bits    = '0;
   logic [31:0]       trig_count   = '0;
   logic [23:0]       chip_header  = '0;

   rdhd_pkg::rsp_type pending_hits[$];   // decoded words not yet popped
   logic [31:0]       frame_words[$];    // datagram being assembled (logical order)
   int                mismatches   = 0;
   int                words_sent   = 0;
   bit                quiet        = 1'b0; // no idling on either side
   bit                hold_request = 1'b0; // ask receiver for one long hold-off

   readout_datagram_hit_decoder uut (
      .clock     (clock),
      .reset     (reset),
      .req_push  (req_push),
      .req_full  (req_full),
      .req_data  (req_data),
      .rsp_empty (rsp_empty),
      .rsp_pop   (rsp_pop),
      .rsp_data  (rsp_data)
   );

   always #5 clock = ~clock;

   // Wire order is byte-reversed; the swap is its own inverse.
   function automatic logic [31:0] byte_swap(input logic [31:0] w);
      return {w[7:0], w[15:8], w[23:16], w[31:24]};
   endfunction

   // Append one word to the datagram being assembled.
   function automatic void add_word(input logic [31:0] w);
      frame_words.insert(frame_words.size(), w);
   endfunction

   // Predictor: applies one accepted word to the mirrored state and queues
   // the result it causes, if any.
   function automatic void decode_word(input rdhd_pkg::req_type item);
      logic [31:0]       w;
      rdhd_pkg::rsp_type hit;
      bit                emit;
      w    = byte_swap(item.raw_word);
      hit  = '0;
      emit = 1'b0;
      case (next_pos)
         rdhd_pkg::POS_LINK:   link_bits   = {w[15:10], w[8], w[5:0]};
         rdhd_pkg::POS_COUNT:  trig_count  = w;
         rdhd_pkg::POS_HEADER: chip_header = {w[31:24], w[15:12], w[11:0]};
         default: begin
            if (!past_trailer) begin
               if (w == rdhd_pkg::TRAILER_WORD) begin
                  past_trailer = 1'b1;
               end else begin
                  // bits 31 and 29 carry nothing
                  hit.channel       = w[27:22];
                  hit.charge        = w[21:12];
                  hit.arrival_time  = w[11:4];
                  hit.rel_bunch     = w[2:0];
                  hit.neighbor      = w[3];
                  hit.hit_flags     = {w[30], w[28]};
                  hit.chip_id       = chip_header[23:16];
                  hit.header_flags  = chip_header[15:12];
                  hit.bunch_id      = chip_header[11:0];
                  hit.trigger_count = trig_count;
                  hit.link_info     = link_bits;
                  emit              = 1'b1;
               end
            end
         end
      endcase
      if (item.end_of_datagram) begin
         // datagram ended inside the header: error word, all else zero
         if (next_pos != rdhd_pkg::POS_HITS) begin
            hit             = '0;
            hit.short_error = 1'b1;
            emit            = 1'b1;
         end
         next_pos     = rdhd_pkg::POS_LINK;
         past_trailer = 1'b0;
      end else begin
         case (next_pos)
            rdhd_pkg::POS_LINK:   next_pos = rdhd_pkg::POS_COUNT;
            rdhd_pkg::POS_COUNT:  next_pos = rdhd_pkg::POS_HEADER;
            default:              next_pos = rdhd_pkg::POS_HITS;
         endcase
      end
      if (emit)
         pending_hits.insert(pending_hits.size(), hit);
   endfunction

   // Offer one word (given in logical order) and wait until it is taken.
   // push stays high afterwards so back-to-back words need no extra edge.
   task automatic send_word(input logic [31:0] word, input logic last);
      int gap;
      gap = 0;
      if (!quiet && $urandom_range(0, 7) == 0)
         gap = $urandom_range(1, 17);
      @(negedge clock);
      if (gap > 0) begin
         req_push <= 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_push                 <= 1'b1;
      req_data.raw_word        <= byte_swap(word);
      req_data.end_of_datagram <= last;
      do @(posedge clock); while (req_full);
      decode_word(req_data);
      words_sent++;
   endtask

   // Send the assembled datagram, marking its final word.
   task automatic send_frame();
      int n;
      n = frame_words.size();
      for (int i = 0; i < n; i++)
         send_word(frame_words[i], i == n - 1);
      frame_words.delete();
   endtask

   // Well-formed datagram: three header words, hits, optional trailer and
   // some ignored words behind it. All content random.
   task automatic build_frame(input int hits, input bit trailer, input int tail);
      repeat (3) add_word($urandom);
      repeat (hits) add_word($urandom);
      if (trailer) begin
         add_word(rdhd_pkg::TRAILER_WORD);
         repeat (tail) add_word($urandom);
      end
   endtask

   // Sender pause: stop offering until every predicted word has come back.
   task automatic wait_for_results();
      @(negedge clock);
      req_push <= 1'b0;
      while (pending_hits.size() != 0) @(posedge clock);
   endtask

   task automatic check_field(input string name, input logic [31:0] want,
                              input logic [31:0] got);
      if (want !== got) begin
         $error("%s: expected 0x%0h, got 0x%0h", name, want, got);
         mismatches++;
      end
   endtask

   // Datagrams that end on word 0, 1 and 2.
   task automatic test_short_datagrams();
      send_word(32'h1234_5678, 1'b1);
      send_word(32'hffff_ffff, 1'b0);
      send_word(32'h0000_0001, 1'b1);
      send_word(32'hdead_beef, 1'b0);
      send_word(32'hffff_ffff, 1'b0);
      send_word(32'hffff_ffff, 1'b1);
   endtask

   // Zero header, then hits with field extremes and alternating bits.
   task automatic test_field_extremes();
      frame_words = '{32'h0, 32'h0, 32'h0,
                      32'h0000_0000, 32'hffff_fffe, 32'haaaa_aaaa,
                      32'h5555_5555, 32'h7fff_ffff};
      send_frame();
   endtask

   // All-ones header words are not trailers; hits after the trailer vanish;
   // a trailer as the final word; the flag clears for the next datagram.
   task automatic test_trailer();
      frame_words = '{32'hffff_ffff, 32'hffff_ffff, 32'hffff_ffff,
                      32'h0fc0_0ff7, rdhd_pkg::TRAILER_WORD, 32'h1234_5678,
                      32'h4000_0008};
      send_frame();
      frame_words = '{32'h0000_fd3f, 32'h8000_0001, 32'hff00_f000,
                      rdhd_pkg::TRAILER_WORD};
      send_frame();
   endtask

   // Receiver holds off while a long datagram is offered, so the queue
   // fills and req_full throttles the sender.
   task automatic test_full_queue();
      hold_request = 1'b1;
      build_frame(24, 1'b0, 0);
      send_frame();
      wait_for_results();
      build_frame(6, 1'b1, 2);
      send_frame();
   endtask

   // Mostly well-formed datagrams, plus short ones and raw noise.
   task automatic test_random_traffic();
      int kind;
      int stop_at;
      stop_at = words_sent + RANDOM_WORDS;
      while (words_sent < stop_at) begin
         kind = $urandom_range(0, 19);
         if (kind < 2) begin
            repeat ($urandom_range(1, 3)) add_word($urandom);
         end else if (kind < 4) begin
            // noise, trailers sprinkled anywhere
            repeat ($urandom_range(1, 8))
               add_word(($urandom_range(0, 3) == 0) ? rdhd_pkg::TRAILER_WORD
                                                    : $urandom);
         end else begin
            build_frame($urandom_range(0, 10), $urandom_range(0, 4) == 0,
                        $urandom_range(0, 3));
         end
         send_frame();
      end
   endtask

   // Back-to-back words with a free-running receiver.
   task automatic test_full_rate();
      quiet = 1'b1;
      repeat (4) begin
         build_frame($urandom_range(4, 12), $urandom_range(0, 1), 1);
         send_frame();
      end
   endtask

   // Receiver: pop most cycles, random stall bursts, one long hold-off on
   // request. One assignment to rsp_pop per falling edge.
   initial begin : receiver
      int stall_left;
      stall_left = 0;
      forever begin
         @(negedge clock);
         if (stall_left > 0) begin
            stall_left--;
            rsp_pop <= 1'b0;
         end else if (hold_request) begin
            hold_request = 1'b0;
            stall_left   = HOLD_CYCLES - 1;
            rsp_pop <= 1'b0;
         end else if (!quiet && $urandom_range(0, 7) == 0) begin
            stall_left = $urandom_range(0, 16);
            rsp_pop <= 1'b0;
         end else begin
            rsp_pop <= 1'b1;
         end
      end
   end

   // Compare every popped word with the oldest prediction.
   always @(posedge clock) begin : check_results
      rdhd_pkg::rsp_type want;
      if (!reset && rsp_pop && !rsp_empty) begin
         if (pending_hits.size() == 0) begin
            $error("result word with nothing predicted: 0x%0h", rsp_data);
            mismatches++;
         end else begin
            want = pending_hits.pop_front();
            check_field("channel", want.channel, rsp_data.channel);
            check_field("charge", want.charge, rsp_data.charge);
            check_field("arrival_time", want.arrival_time, rsp_data.arrival_time);
            check_field("rel_bunch", want.rel_bunch, rsp_data.rel_bunch);
            check_field("neighbor", want.neighbor, rsp_data.neighbor);
            check_field("hit_flags", want.hit_flags, rsp_data.hit_flags);
            check_field("chip_id", want.chip_id, rsp_data.chip_id);
            check_field("bunch_id", want.bunch_id, rsp_data.bunch_id);
            check_field("header_flags", want.header_flags, rsp_data.header_flags);
            check_field("trigger_count", want.trigger_count, rsp_data.trigger_count);
            check_field("link_info", want.link_info, rsp_data.link_info);
            check_field("short_error", want.short_error, rsp_data.short_error);
         end
      end
   end

   initial begin
      repeat (10) @(negedge clock);
      reset <= 1'b0;
      test_short_datagrams();
      test_field_extremes();
      test_trailer();
      test_full_queue();
      test_random_traffic();
      test_full_rate();
      wait_for_results();
      // leave room for any stray word
      repeat (20) @(posedge clock);
      if (mismatches == 0 && pending_hits.size() == 0)
         $display("readout_datagram_hit_decoder_test: clean");
      else
         $display("readout_datagram_hit_decoder_test: errors");
      $finish;
   end

   // Watchdog, far beyond the slowest legal run.
   initial begin
      #2_000_000;
      $display("readout_datagram_hit_decoder_test: errors");
      $finish;
   end

endmodule
